[hdl/cse_pkg.sv]
// Shared types and constants for the cosine similarity engine.
// No dependencies; imported by the controller, datapath and top level.
package cse_pkg;

    localparam int ELEM_BITS  = 16;
    localparam int ACC_BITS   = 48;
    localparam int ROOT_BITS  = ACC_BITS / 2;
    localparam int SIM_BITS   = 16;
    localparam int FRAC_BITS  = 15;
    localparam int NUM_BITS   = ACC_BITS + FRAC_BITS;
    localparam int CNT_BITS   = 6;
    localparam int MAX_ELEMENTS = 1024;

    localparam logic [CNT_BITS-1:0] SQRT_LAST = CNT_BITS'(ROOT_BITS - 1);
    localparam logic [CNT_BITS-1:0] DIV_LAST  = CNT_BITS'(NUM_BITS - 1);

    typedef struct packed {
        logic signed [ELEM_BITS-1:0] a_elem;
        logic signed [ELEM_BITS-1:0] b_elem;
        logic                        last;
    } cse_in_t;

    typedef struct packed {
        logic signed [SIM_BITS-1:0] similarity;
        logic                       zero_magnitude;
    } cse_out_t;

    typedef struct packed {
        logic accum;
        logic capture;
        logic sqrt_step;
        logic mul;
        logic prep;
        logic div_step;
        logic finish;
    } cse_cmd_t;

    typedef struct packed {
        logic zero_mag;
    } cse_status_t;

endpackage

[hdl/cse_datapath.sv]
// Datapath: accumulators, bit-serial square roots, root multiplier and
// restoring divider, plus the result register. Depends on cse_pkg.
module cse_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cse_pkg::cse_cmd_t    cmd,
    input  cse_pkg::cse_in_t     in_data,
    output cse_pkg::cse_status_t status,
    output cse_pkg::cse_out_t    out_data
);
    import cse_pkg::*;

    typedef struct packed {
        logic [ROOT_BITS+1:0] rem;
        logic [ROOT_BITS-1:0] root;
    } sq_t;

    function automatic sq_t sqrt_step(input logic [ROOT_BITS+1:0] rem,
                                      input logic [ROOT_BITS-1:0] root,
                                      input logic [1:0] bits2);
        logic [ROOT_BITS+3:0] rem_sh;
        logic [ROOT_BITS+3:0] trial;
        sq_t r;
        rem_sh = {rem, bits2};
        trial  = {2'b00, root, 2'b01};
        if (rem_sh >= trial)
        begin
            r.rem  = (ROOT_BITS+2)'(rem_sh - trial);
            r.root = {root[ROOT_BITS-2:0], 1'b1};
        end
        else
        begin
            r.rem  = (ROOT_BITS+2)'(rem_sh);
            r.root = {root[ROOT_BITS-2:0], 1'b0};
        end
        return r;
    endfunction

    logic signed [ACC_BITS-1:0] dot_reg, dot_next;
    logic [ACC_BITS-1:0]        mag_a_reg, mag_a_next;
    logic [ACC_BITS-1:0]        mag_b_reg, mag_b_next;
    logic                       zero_reg;
    logic                       neg_reg;
    logic [ACC_BITS-1:0]        dot_mag_reg;
    logic [ACC_BITS-1:0]        xa_reg, xb_reg;
    logic [ROOT_BITS+1:0]       rema_reg, remb_reg;
    logic [ROOT_BITS-1:0]       roota_reg, rootb_reg;
    logic [ACC_BITS-1:0]        den_reg;
    logic [NUM_BITS-1:0]        num_reg;
    logic [ACC_BITS-1:0]        drem_reg;
    logic [NUM_BITS-1:0]        quo_reg;
    cse_out_t                   result_reg;

    logic signed [2*ELEM_BITS-1:0] prod_ab, prod_aa, prod_bb;
    logic signed [ACC_BITS:0]      dot_sum;
    logic [ACC_BITS:0]             sum_a, sum_b;
    sq_t                           sa, sb;
    logic [ACC_BITS:0]             drem_sh;
    logic [FRAC_BITS+1:0]          q_sat;

    // Multiply the element pair and add with saturation
    always_comb
    begin
        prod_ab = in_data.a_elem * in_data.b_elem;
        prod_aa = in_data.a_elem * in_data.a_elem;
        prod_bb = in_data.b_elem * in_data.b_elem;
        dot_sum = (ACC_BITS+1)'(dot_reg) + (ACC_BITS+1)'(prod_ab);
        sum_a   = {1'b0, mag_a_reg} + (ACC_BITS+1)'(unsigned'(prod_aa));
        sum_b   = {1'b0, mag_b_reg} + (ACC_BITS+1)'(unsigned'(prod_bb));
        if (dot_sum[ACC_BITS] != dot_sum[ACC_BITS-1])
            dot_next = dot_sum[ACC_BITS] ? {1'b1, {(ACC_BITS-1){1'b0}}}
                                         : {1'b0, {(ACC_BITS-1){1'b1}}};
        else
            dot_next = dot_sum[ACC_BITS-1:0];
        mag_a_next = sum_a[ACC_BITS] ? {ACC_BITS{1'b1}} : sum_a[ACC_BITS-1:0];
        mag_b_next = sum_b[ACC_BITS] ? {ACC_BITS{1'b1}} : sum_b[ACC_BITS-1:0];
    end

    always_comb
    begin
        sa      = sqrt_step(rema_reg, roota_reg, xa_reg[ACC_BITS-1:ACC_BITS-2]);
        sb      = sqrt_step(remb_reg, rootb_reg, xb_reg[ACC_BITS-1:ACC_BITS-2]);
        drem_sh = {drem_reg, num_reg[NUM_BITS-1]};
    end

    // Saturate the quotient to Q1.15
    always_comb
    begin
        q_sat = '0;
        if (neg_reg)
        begin
            if (quo_reg > NUM_BITS'(1 << FRAC_BITS))
                q_sat = (FRAC_BITS+2)'(1 << FRAC_BITS);
            else
                q_sat = quo_reg[FRAC_BITS+1:0];
            q_sat = (FRAC_BITS+2)'(~q_sat + 1'b1);
        end
        else
        begin
            if (quo_reg > NUM_BITS'((1 << FRAC_BITS) - 1))
                q_sat = (FRAC_BITS+2)'((1 << FRAC_BITS) - 1);
            else
                q_sat = quo_reg[FRAC_BITS+1:0];
        end
    end

    // Accumulators: advance on each transaction, clear on the last one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg   <= '0;
            mag_a_reg <= '0;
            mag_b_reg <= '0;
        end
        else if (cmd.accum)
        begin
            if (cmd.capture)
            begin
                dot_reg   <= '0;
                mag_a_reg <= '0;
                mag_b_reg <= '0;
            end
            else
            begin
                dot_reg   <= dot_next;
                mag_a_reg <= mag_a_next;
                mag_b_reg <= mag_b_next;
            end
        end
    end

    // Work registers for root, product, divide and result
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            zero_reg    <= (mag_a_next == '0) || (mag_b_next == '0);
            neg_reg     <= dot_next[ACC_BITS-1];
            dot_mag_reg <= dot_next[ACC_BITS-1] ? ACC_BITS'(-dot_next)
                                                : ACC_BITS'(dot_next);
            xa_reg      <= mag_a_next;
            xb_reg      <= mag_b_next;
            rema_reg    <= '0;
            remb_reg    <= '0;
            roota_reg   <= '0;
            rootb_reg   <= '0;
        end
        if (cmd.sqrt_step)
        begin
            xa_reg    <= {xa_reg[ACC_BITS-3:0], 2'b00};
            xb_reg    <= {xb_reg[ACC_BITS-3:0], 2'b00};
            rema_reg  <= sa.rem;
            remb_reg  <= sb.rem;
            roota_reg <= sa.root;
            rootb_reg <= sb.root;
        end
        if (cmd.mul)
            den_reg <= roota_reg * rootb_reg;
        if (cmd.prep)
        begin
            num_reg  <= {dot_mag_reg, {FRAC_BITS{1'b0}}}
                      + NUM_BITS'(den_reg[ACC_BITS-1:1]);
            drem_reg <= '0;
            quo_reg  <= '0;
        end
        if (cmd.div_step)
        begin
            num_reg <= {num_reg[NUM_BITS-2:0], 1'b0};
            if (drem_sh >= {1'b0, den_reg})
            begin
                drem_reg <= ACC_BITS'(drem_sh - {1'b0, den_reg});
                quo_reg  <= {quo_reg[NUM_BITS-2:0], 1'b1};
            end
            else
            begin
                drem_reg <= drem_sh[ACC_BITS-1:0];
                quo_reg  <= {quo_reg[NUM_BITS-2:0], 1'b0};
            end
        end
        if (cmd.finish)
        begin
            result_reg.zero_magnitude <= zero_reg;
            result_reg.similarity     <= zero_reg ? '0 : q_sat[SIM_BITS-1:0];
        end
    end

    assign status.zero_mag = zero_reg;
    assign out_data        = result_reg;

endmodule

[hdl/cse_controller.sv]
// Controller state machine: sequences accumulate, root, multiply, divide
// and result hand-off. Depends on cse_pkg.
module cse_controller (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_last,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  cse_pkg::cse_status_t status,
    output cse_pkg::cse_cmd_t    cmd
);
    import cse_pkg::*;

    typedef enum logic [5:0] {
        ST_ACCUM = 6'b000001,
        ST_SQRT  = 6'b000010,
        ST_MUL   = 6'b000100,
        ST_PREP  = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                out_valid_reg, out_valid_next;
    logic                slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        in_ready       = 1'b0;
        unique case (state_reg)
            ST_ACCUM:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accum = 1'b1;
                    if (in_last)
                    begin
                        cmd.capture = 1'b1;
                        cnt_next    = '0;
                        state_next  = ST_SQRT;
                    end
                end
            end
            ST_SQRT:
            begin
                if (status.zero_mag)
                    state_next = ST_DONE;
                else
                begin
                    cmd.sqrt_step = 1'b1;
                    cnt_next      = cnt_reg + 1'b1;
                    if (cnt_reg == SQRT_LAST)
                        state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_PREP;
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_ACCUM;
                end
            end
            default:
                state_next = ST_ACCUM;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACCUM;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_capture_to_sqrt: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> state_reg == ST_SQRT)
        else $error("capture did not start the root pass");

    a_div_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && cnt_reg == DIV_LAST) |=> state_reg == ST_DONE)
        else $error("divide did not end after its last step");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid_reg || out_ready))
        else $error("result overwritten while pending");

    a_accum_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accum |-> state_reg == ST_ACCUM)
        else $error("accumulate outside the accumulate state");

endmodule

[hdl/cosine_similarity_engine.sv]
// Top level of the cosine similarity engine.
// Depends on cse_pkg, cse_controller and cse_datapath.
//
// Usage:
//   Input channel in_valid/in_ready/in_data carries one element pair
//   (a_elem, b_elem, last) per transaction. Output channel
//   out_valid/out_ready/out_data carries one result (similarity in Q1.15,
//   zero_magnitude) for each pair marked last.
//   Pairs accumulate at one per cycle while in_ready is high. After the last
//   pair the block runs bit-serial square roots (both 24-bit roots in
//   parallel), one multiply, one setup step and a restoring division of 63
//   quotient bits, one bit per step; the result register then loads once
//   the output slot is free. With a zero magnitude the root, multiply and
//   divide passes are skipped. in_ready is low from the last pair until
//   the result is loaded.
//   A result waits in the output register while the receiver stalls; the
//   next vector is accepted meanwhile, and only a second result waits.
//   Reset clears the accumulators, the controller and out_valid.
module cosine_similarity_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  cse_pkg::cse_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output cse_pkg::cse_out_t out_data
);
    import cse_pkg::*;

    cse_cmd_t    cmd;
    cse_status_t status;

    cse_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_last   (in_data.last),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    cse_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_data  (in_data),
        .status   (status),
        .out_data (out_data)
    );

endmodule
